// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SGFM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgfm assertion failed");

// consequent checked from the cycle after the antecedent
`define SGFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgfm assertion failed");

`endif

// ===== rtl/sgfm_pkg.sv =====
// shared types, constants and codes of the sparse grid first moment block
// no dependencies
package sgfm_pkg;

    // dimensions in use and number of bound register pairs
    localparam int DIMS      = 4;
    localparam int LANES     = 4;
    localparam int MAX_LEVEL = 16;

    localparam int LEVEL_W   = 5;
    localparam int INDEX_W   = 16;
    localparam int BOUND_W   = 32;
    localparam int MOMENT_W  = 64;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_IDX_W = (DIMS > 1) ? $clog2(DIMS) : 1;

    // level 0 means in unsigned Q0.32, truncated
    localparam logic [31:0] Q32_ONE_THIRD = 32'd1431655765;
    localparam logic [31:0] Q32_ONE_SIXTH = 32'd715827882;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // reset bounds: the unit interval in Q16.16
    localparam logic signed [BOUND_W-1:0] LOWER_RESET = 32'sd0;
    localparam logic signed [BOUND_W-1:0] UPPER_RESET = 32'sd65536;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_0 = 3'd0,
        CFG_UPPER_0 = 3'd1,
        CFG_LOWER_1 = 3'd2,
        CFG_UPPER_1 = 3'd3,
        CFG_LOWER_2 = 3'd4,
        CFG_UPPER_2 = 3'd5,
        CFG_LOWER_3 = 3'd6,
        CFG_UPPER_3 = 3'd7
    } sgfm_cfg_reg_t;

    // one grid point
    typedef struct packed {
        logic [LEVEL_W-1:0]        level_0;
        logic [INDEX_W-1:0]        index_0;
        logic [LEVEL_W-1:0]        level_1;
        logic [INDEX_W-1:0]        index_1;
        logic [LEVEL_W-1:0]        level_2;
        logic [INDEX_W-1:0]        index_2;
        logic [LEVEL_W-1:0]        level_3;
        logic [INDEX_W-1:0]        index_3;
        logic signed [BOUND_W-1:0] surplus;
        logic                      last_point;
    } sgfm_point_t;

    // one result
    typedef struct packed {
        logic signed [MOMENT_W-1:0] moment;
        logic                       saturated;
    } sgfm_result_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE_MUL,
        ST_LANE_SUM,
        ST_LOAD,
        ST_PROD_MUL,
        ST_PROD_RND,
        ST_TERM_MUL,
        ST_ACCUM
    } sgfm_state_t;

    // stage enables for the lanes
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } sgfm_lane_ctrl_t;

    // strobes for the merge stage
    typedef struct packed {
        logic                 load;
        logic                 prod_mul;
        logic                 prod_rnd;
        logic                 term_mul;
        logic                 accum;
        logic                 clear;
        logic [DIM_IDX_W-1:0] step;
    } sgfm_merge_ctrl_t;

endpackage

// ===== rtl/sgfm_lane.sv =====
// one dimension lane: factor = (upper - lower) * mean + lower * quad
// depends on sgfm_pkg
module sgfm_lane
    import sgfm_pkg::*;
(
    input  logic                      clk,
    input  sgfm_lane_ctrl_t           ctrl,
    input  logic signed [BOUND_W-1:0] lower,
    input  logic signed [BOUND_W-1:0] upper,
    input  logic [LEVEL_W-1:0]        level,
    input  logic [INDEX_W-1:0]        index,
    output logic signed [BOUND_W-1:0] factor,
    output logic                      factor_ovf
);

    logic [LEVEL_W-1:0]        lv;
    logic [5:0]                mean_shift;
    logic [47:0]               mean_wide;
    logic [31:0]               mean;
    logic                      mean_sat;
    logic [4:0]                quad_shift;
    logic signed [32:0]        span;
    logic signed [65:0]        mean_mul_next;
    logic signed [63:0]        lo_quad_next;
    logic signed [65:0]        mean_mul_reg;
    logic signed [63:0]        lo_quad_reg;
    logic                      mean_sat_reg;
    logic signed [65:0]        total;
    logic [33:0]               total_hi;
    logic                      fac_sat;
    logic signed [BOUND_W-1:0] factor_next;
    logic signed [BOUND_W-1:0] factor_reg;
    logic                      factor_ovf_reg;

    // level clamp and the mean and quad weights
    always_comb
    begin
        lv         = (level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : level;
        mean_shift = 6'd32 - {lv, 1'b0};
        mean_wide  = 48'(index) << mean_shift;
        if (lv == '0)
        begin
            mean       = (index == '0) ? Q32_ONE_THIRD : Q32_ONE_SIXTH;
            mean_sat   = 1'b0;
            quad_shift = 5'd31;
        end
        else
        begin
            // index at or above 4^level gives a mean of one or more
            mean_sat   = |mean_wide[47:32];
            mean       = mean_sat ? 32'hFFFF_FFFF : mean_wide[31:0];
            quad_shift = 5'(6'd32 - 6'(lv));
        end
    end

    // first stage: span times mean, lower times quad
    always_comb
    begin
        span          = $signed({upper[BOUND_W-1], upper}) - $signed({lower[BOUND_W-1], lower});
        mean_mul_next = span * $signed({1'b0, mean});
        lo_quad_next  = $signed({{32{lower[BOUND_W-1]}}, lower}) <<< quad_shift;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            mean_mul_reg <= mean_mul_next;
            lo_quad_reg  <= lo_quad_next;
            mean_sat_reg <= mean_sat;
        end
    end

    // second stage: sum, round to Q16.16 and saturate
    always_comb
    begin
        total    = mean_mul_reg + 66'(lo_quad_reg) + 66'sh0_8000_0000;
        total_hi = total[65:32];
        fac_sat  = !((total_hi[33:31] == 3'b000) || (total_hi[33:31] == 3'b111));
        if (fac_sat)
        begin
            factor_next = total_hi[33] ? S32_MIN : S32_MAX;
        end
        else
        begin
            factor_next = $signed(total_hi[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            factor_reg     <= factor_next;
            factor_ovf_reg <= fac_sat || mean_sat_reg;
        end
    end

    assign factor     = factor_reg;
    assign factor_ovf = factor_ovf_reg;

endmodule

// ===== rtl/sgfm_merge.sv =====
// merge stage: product of lane factors on one shared multiplier,
// surplus term and the saturating Q32.32 accumulator; depends on sgfm_pkg
module sgfm_merge
    import sgfm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sgfm_merge_ctrl_t           ctrl,
    input  logic signed [BOUND_W-1:0]  factor [DIMS],
    input  logic [DIMS-1:0]            factor_ovf,
    input  logic signed [BOUND_W-1:0]  surplus,
    output logic signed [MOMENT_W-1:0] moment_next,
    output logic                       saturated_next
);

    logic signed [BOUND_W-1:0]  acc_reg;
    logic signed [63:0]         mul_reg;
    logic                       item_ovf_reg;
    logic signed [MOMENT_W-1:0] sum_reg;
    logic                       seen_reg;
    logic signed [63:0]         rounded;
    logic [47:0]                rnd_hi;
    logic                       rnd_sat;
    logic signed [BOUND_W-1:0]  acc_rnd;
    logic signed [64:0]         sum_wide;
    logic                       sum_sat;

    // rounding of the running product back to Q16.16
    always_comb
    begin
        rounded = mul_reg + 64'sd32768;
        rnd_hi  = rounded[63:16];
        rnd_sat = !((rnd_hi[47:31] == '0) || (rnd_hi[47:31] == '1));
        if (rnd_sat)
        begin
            acc_rnd = rnd_hi[47] ? S32_MIN : S32_MAX;
        end
        else
        begin
            acc_rnd = $signed(rnd_hi[31:0]);
        end
    end

    // saturating add of the term into the total
    always_comb
    begin
        sum_wide = $signed({sum_reg[MOMENT_W-1], sum_reg}) + $signed({mul_reg[63], mul_reg});
        sum_sat  = sum_wide[64] != sum_wide[63];
        if (sum_sat)
        begin
            moment_next = sum_wide[64] ? S64_MIN : S64_MAX;
        end
        else
        begin
            moment_next = sum_wide[63:0];
        end
        saturated_next = seen_reg || item_ovf_reg || sum_sat;
    end

    // product chain and term
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_reg      <= factor[0];
            item_ovf_reg <= |factor_ovf;
        end
        else if (ctrl.prod_rnd)
        begin
            acc_reg      <= acc_rnd;
            item_ovf_reg <= item_ovf_reg || rnd_sat;
        end
        if (ctrl.prod_mul)
        begin
            mul_reg <= acc_reg * factor[ctrl.step];
        end
        else if (ctrl.term_mul)
        begin
            mul_reg <= acc_reg * surplus;
        end
    end

    // run total and saturation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else if (ctrl.accum)
        begin
            if (ctrl.clear)
            begin
                sum_reg  <= '0;
                seen_reg <= 1'b0;
            end
            else
            begin
                sum_reg  <= moment_next;
                seen_reg <= saturated_next;
            end
        end
    end

endmodule

// ===== rtl/sparse_grid_first_moment.sv =====
// top level of the sparse grid first moment block: bounds, point register,
// sequencer, lanes and merge stage; depends on sgfm_pkg, sgfm_lane, sgfm_merge
//
// channel  dir  handshake                    payload
// point    in   point_valid / point_stall    sgfm_point_t
// result   out  result_valid / result_stall  sgfm_result_t (last points only)
// config   in   cfg_write                    cfg_index, cfg_data
//
// a new point is taken only once the last one has left the accumulate state;
// the shared multiplier of the merge stage steps through the factor product,
// then forms the surplus term
// reset sets the bounds to [0,1] and clears the total and the flag
// a last point waits in the accumulate step while an earlier result is held
module sparse_grid_first_moment
    import sgfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_stall,
    input  sgfm_point_t          point,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sgfm_result_t         result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BOUND_W-1:0]   cfg_data
);

    sgfm_state_t               state_reg;
    sgfm_state_t               state_next;
    logic [DIM_IDX_W-1:0]      step_reg;
    logic [DIM_IDX_W-1:0]      step_next;
    logic signed [BOUND_W-1:0] lower_reg [LANES];
    logic signed [BOUND_W-1:0] upper_reg [LANES];
    sgfm_point_t               point_reg;
    logic [LEVEL_W-1:0]        level_arr [LANES];
    logic [INDEX_W-1:0]        index_arr [LANES];
    logic signed [BOUND_W-1:0] factor_arr [DIMS];
    logic [DIMS-1:0]           factor_ovf;
    sgfm_lane_ctrl_t           lane_ctrl;
    sgfm_merge_ctrl_t          merge_ctrl;
    logic signed [MOMENT_W-1:0] moment_next;
    logic                      saturated_next;
    logic                      point_accept;
    logic                      emit_blocked;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    sgfm_result_t              result_reg;

    assign point_accept = point_valid && !point_stall;
    assign point_stall  = state_reg != ST_IDLE;
    // a last point must not overwrite a result still waiting
    assign emit_blocked = point_reg.last_point && result_valid_reg && result_stall;

    // bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lower_reg[i] <= LOWER_RESET;
                upper_reg[i] <= UPPER_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (sgfm_cfg_reg_t'(cfg_index))
                CFG_LOWER_0: lower_reg[0] <= $signed(cfg_data);
                CFG_UPPER_0: upper_reg[0] <= $signed(cfg_data);
                CFG_LOWER_1: lower_reg[1] <= $signed(cfg_data);
                CFG_UPPER_1: upper_reg[1] <= $signed(cfg_data);
                CFG_LOWER_2: lower_reg[2] <= $signed(cfg_data);
                CFG_UPPER_2: upper_reg[2] <= $signed(cfg_data);
                CFG_LOWER_3: lower_reg[3] <= $signed(cfg_data);
                CFG_UPPER_3: upper_reg[3] <= $signed(cfg_data);
                default:     ;
            endcase
        end
    end

    // point register
    always_ff @(posedge clk)
    begin
        if (point_accept)
        begin
            point_reg <= point;
        end
    end

    // per-dimension view of the held point
    always_comb
    begin
        level_arr[0] = point_reg.level_0;
        index_arr[0] = point_reg.index_0;
        level_arr[1] = point_reg.level_1;
        index_arr[1] = point_reg.index_1;
        level_arr[2] = point_reg.level_2;
        index_arr[2] = point_reg.index_2;
        level_arr[3] = point_reg.level_3;
        index_arr[3] = point_reg.index_3;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (point_accept)
                begin
                    state_next = ST_LANE_MUL;
                end
            end
            ST_LANE_MUL: state_next = ST_LANE_SUM;
            ST_LANE_SUM: state_next = ST_LOAD;
            ST_LOAD:
            begin
                step_next  = DIM_IDX_W'(1);
                state_next = (DIMS > 1) ? ST_PROD_MUL : ST_TERM_MUL;
            end
            ST_PROD_MUL: state_next = ST_PROD_RND;
            ST_PROD_RND:
            begin
                step_next  = step_reg + DIM_IDX_W'(1);
                state_next = (step_reg == DIM_IDX_W'(DIMS - 1)) ? ST_TERM_MUL : ST_PROD_MUL;
            end
            ST_TERM_MUL: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (!emit_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // strobes
    always_comb
    begin
        lane_ctrl.mul_en    = state_reg == ST_LANE_MUL;
        lane_ctrl.sum_en    = state_reg == ST_LANE_SUM;
        merge_ctrl.load     = state_reg == ST_LOAD;
        merge_ctrl.prod_mul = state_reg == ST_PROD_MUL;
        merge_ctrl.prod_rnd = state_reg == ST_PROD_RND;
        merge_ctrl.term_mul = state_reg == ST_TERM_MUL;
        merge_ctrl.accum    = (state_reg == ST_ACCUM) && !emit_blocked;
        merge_ctrl.clear    = point_reg.last_point;
        merge_ctrl.step     = step_reg;
    end

    // one lane per dimension
    for (genvar d = 0; d < DIMS; d++)
    begin : g_lane
        sgfm_lane u_lane (
            .clk        (clk),
            .ctrl       (lane_ctrl),
            .lower      (lower_reg[d]),
            .upper      (upper_reg[d]),
            .level      (level_arr[d]),
            .index      (index_arr[d]),
            .factor     (factor_arr[d]),
            .factor_ovf (factor_ovf[d])
        );
    end

    sgfm_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (merge_ctrl),
        .factor         (factor_arr),
        .factor_ovf     (factor_ovf),
        .surplus        (point_reg.surplus),
        .moment_next    (moment_next),
        .saturated_next (saturated_next)
    );

    // result register
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (merge_ctrl.accum && point_reg.last_point)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge_ctrl.accum && point_reg.last_point)
        begin
            result_reg.moment    <= moment_next;
            result_reg.saturated <= saturated_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/sgfm_checker.sv =====
// port-level checks of the sparse grid first moment block and their bind
// depends on sgfm_pkg and assert_macros.svh
`include "assert_macros.svh"

module sgfm_checker
    import sgfm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 point_valid,
    input logic                 point_stall,
    input sgfm_point_t          point,
    input logic                 result_valid,
    input logic                 result_stall,
    input sgfm_result_t         result,
    input logic                 cfg_write,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [BOUND_W-1:0]   cfg_data
);

    // a held result stays put until taken
    `SGFM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // the block stays busy in the lane states after taking an item
    `SGFM_ASSERT_NEXT(a_busy_after_accept, point_valid && !point_stall, point_stall ##1 point_stall)

    // an item that is not a last point raises no result
    `SGFM_ASSERT_NEXT(a_no_result_mid_run,
        point_valid && !point_stall && !point.last_point && !result_valid, !result_valid)

    // configuration writes only land while no item is in the block
    `SGFM_ASSERT_NOW(a_cfg_known, cfg_write, !point_stall && !$isunknown({cfg_index, cfg_data}))

endmodule

bind sparse_grid_first_moment sgfm_checker u_sgfm_checker (.*);

// ===== sim/tb.sv =====
// self-checking testbench for the sparse grid first moment block
// depends on sgfm_pkg and sparse_grid_first_moment; nothing else is read
module tb;
    import sgfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT = 600000;
    localparam int     SETTLE_CYCLES = 30;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_POINTS = 330;
    localparam longint ROUND_Q32 = 64'sh8000_0000;

    typedef enum int { BOUNDS_UNIT, BOUNDS_NARROW, BOUNDS_WIDE, BOUNDS_EXTREME } bound_style_t;

    localparam bound_style_t PHASE_STYLE [RANDOM_PHASES] =
        '{BOUNDS_NARROW, BOUNDS_WIDE, BOUNDS_EXTREME, BOUNDS_NARROW, BOUNDS_EXTREME, BOUNDS_UNIT};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 point_valid = 1'b0;
    logic                 point_stall;
    sgfm_point_t          point = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    sgfm_result_t         result;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BOUND_W-1:0]   cfg_data = '0;

    // predicted block state: bounds, running total, saturation flag
    logic signed [BOUND_W-1:0]  lower_b [LANES];
    logic signed [BOUND_W-1:0]  upper_b [LANES];
    logic signed [MOMENT_W-1:0] moment_total = '0;
    logic                       sat_flag = 1'b0;

    sgfm_point_t  feed_q [$];
    sgfm_result_t moment_q [$];

    logic point_taken = 1'b0;
    bit   idle_on = 1'b1;
    int   send_gap = 0;
    int   hold_left = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    sparse_grid_first_moment uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // saturate to signed 32 bits, noting any clipping
    function automatic longint clamp32(longint v);
        if (v > longint'(S32_MAX))
        begin
            sat_flag = 1'b1;
            return longint'(S32_MAX);
        end
        if (v < longint'(S32_MIN))
        begin
            sat_flag = 1'b1;
            return longint'(S32_MIN);
        end
        return v;
    endfunction

    // per-dimension factor (upper-lower)*mean + lower*quad, rounded to q16.16
    function automatic longint dim_factor(int lane, logic [LEVEL_W-1:0] lvl,
                                          logic [INDEX_W-1:0] idx);
        int unsigned lv;
        logic [63:0] mean, quad, p1, p2, mag_d, mag_lo;
        longint      lo, d, h1, l1, h2, l2, low_part;
        lv = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
        if (lv == 0)
        begin
            mean = (idx == 0) ? {32'd0, Q32_ONE_THIRD} : {32'd0, Q32_ONE_SIXTH};
            quad = 64'h8000_0000;
        end
        else
        begin
            mean = {48'd0, idx} << (32 - 2 * lv);
            // mean of one or more clips to the largest q0.32 value
            if (mean > 64'hFFFF_FFFF)
            begin
                mean = 64'hFFFF_FFFF;
                sat_flag = 1'b1;
            end
            quad = 64'd1 << (32 - lv);
        end
        lo = longint'(lower_b[lane]);
        d = longint'(upper_b[lane]) - lo;
        mag_d = (d < 0) ? -d : d;
        mag_lo = (lo < 0) ? -lo : lo;
        p1 = mag_d * mean;
        p2 = mag_lo * quad;
        h1 = longint'(p1 >> 32);
        l1 = longint'({32'd0, p1[31:0]});
        h2 = longint'(p2 >> 32);
        l2 = longint'({32'd0, p2[31:0]});
        if (d < 0)
        begin
            h1 = -h1;
            l1 = -l1;
        end
        if (lo < 0)
        begin
            h2 = -h2;
            l2 = -l2;
        end
        low_part = l1 + l2 + ROUND_Q32;
        return clamp32(h1 + h2 + (low_part >>> 32));
    endfunction

    // fold one accepted point into the predicted total
    function automatic void absorb_point(sgfm_point_t pt);
        logic [LEVEL_W-1:0] lvls [LANES];
        logic [INDEX_W-1:0] idxs [LANES];
        longint             prod, f, term;
        logic [64:0]        wide;
        sgfm_result_t       exp_res;
        lvls[0] = pt.level_0;
        idxs[0] = pt.index_0;
        lvls[1] = pt.level_1;
        idxs[1] = pt.index_1;
        lvls[2] = pt.level_2;
        idxs[2] = pt.index_2;
        lvls[3] = pt.level_3;
        idxs[3] = pt.index_3;
        prod = 65536;
        for (int d = 0; d < DIMS; d++)
        begin
            f = dim_factor(d, lvls[d], idxs[d]);
            prod = clamp32((prod * f + 32768) >>> 16);
        end
        term = longint'($signed(pt.surplus)) * prod;
        // saturating q32.32 accumulate
        wide = {moment_total[63], moment_total} + {term[63], term};
        if (wide[64] != wide[63])
        begin
            moment_total = wide[64] ? S64_MIN : S64_MAX;
            sat_flag = 1'b1;
        end
        else
            moment_total = wide[63:0];
        if (pt.last_point)
        begin
            exp_res.moment = moment_total;
            exp_res.saturated = sat_flag;
            moment_q.push_back(exp_res);
            moment_total = '0;
            sat_flag = 1'b0;
        end
    endfunction

    // compare one result item with the oldest predicted total
    function automatic void check_result(sgfm_result_t got);
        sgfm_result_t want;
        if (moment_q.size() == 0)
        begin
            $error("result item with no predicted total waiting");
            mismatch_count++;
            return;
        end
        want = moment_q.pop_front();
        if (got.moment !== want.moment)
        begin
            $error("moment: expected %0d, actual %0d", want.moment, got.moment);
            mismatch_count++;
        end
        if (got.saturated !== want.saturated)
        begin
            $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
            mismatch_count++;
        end
    endfunction

    // same level and index in every dimension
    function automatic sgfm_point_t uniform_point(logic [LEVEL_W-1:0] lv,
                                                  logic [INDEX_W-1:0] idx,
                                                  logic signed [BOUND_W-1:0] surplus,
                                                  logic last);
        sgfm_point_t pt;
        pt.level_0 = lv;
        pt.index_0 = idx;
        pt.level_1 = lv;
        pt.index_1 = idx;
        pt.level_2 = lv;
        pt.index_2 = idx;
        pt.level_3 = lv;
        pt.index_3 = idx;
        pt.surplus = surplus;
        pt.last_point = last;
        return pt;
    endfunction

    // mostly proper hierarchical points, some raw levels and indexes
    function automatic sgfm_point_t random_point(logic last);
        logic [LEVEL_W-1:0] lvls [LANES];
        logic [INDEX_W-1:0] idxs [LANES];
        int unsigned        pick, top;
        sgfm_point_t        pt;
        for (int d = 0; d < LANES; d++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                lvls[d] = '0;
                idxs[d] = INDEX_W'($urandom_range(0, 1));
            end
            else if (pick < 7)
            begin
                top = ($urandom_range(0, 3) == 0) ? MAX_LEVEL : 5;
                lvls[d] = LEVEL_W'($urandom_range(1, top));
                idxs[d] = INDEX_W'(2 * $urandom_range(0, (1 << (lvls[d] - 1)) - 1) + 1);
            end
            else if (pick == 7)
            begin
                lvls[d] = LEVEL_W'($urandom_range(0, 31));
                idxs[d] = INDEX_W'($urandom);
            end
            else
            begin
                lvls[d] = LEVEL_W'($urandom_range(0, 3));
                idxs[d] = INDEX_W'($urandom);
            end
        end
        pt.level_0 = lvls[0];
        pt.index_0 = idxs[0];
        pt.level_1 = lvls[1];
        pt.index_1 = idxs[1];
        pt.level_2 = lvls[2];
        pt.index_2 = idxs[2];
        pt.level_3 = lvls[3];
        pt.index_3 = idxs[3];
        if ($urandom_range(0, 1) == 0)
            pt.surplus = $urandom;
        else
            pt.surplus = int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
        pt.last_point = last;
        return pt;
    endfunction

    // a bound value of the chosen flavour
    function automatic logic [BOUND_W-1:0] pick_bound(bound_style_t style,
                                                     sgfm_cfg_reg_t which);
        logic is_upper;
        is_upper = which inside {CFG_UPPER_0, CFG_UPPER_1, CFG_UPPER_2, CFG_UPPER_3};
        case (style)
            BOUNDS_UNIT:   return is_upper ? UPPER_RESET : LOWER_RESET;
            BOUNDS_NARROW: return int'($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
            BOUNDS_WIDE:   return $urandom;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return S32_MIN;
                    1:       return S32_MAX;
                    2:       return '0;
                    default: return -32'sd65536;
                endcase
            end
        endcase
    endfunction

    // write one bound register and mirror it in the prediction
    task automatic program_bound(sgfm_cfg_reg_t which, logic [BOUND_W-1:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data <= v;
        case (which)
            CFG_LOWER_0: lower_b[0] = v;
            CFG_UPPER_0: upper_b[0] = v;
            CFG_LOWER_1: lower_b[1] = v;
            CFG_UPPER_1: upper_b[1] = v;
            CFG_LOWER_2: lower_b[2] = v;
            CFG_UPPER_2: upper_b[2] = v;
            CFG_LOWER_3: lower_b[3] = v;
            CFG_UPPER_3: upper_b[3] = v;
            default:     ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for every queued point to go in and every total to come out
    task automatic drain();
        do @(posedge clk); while (feed_q.size() != 0 || point_valid);
        do @(negedge clk); while (moment_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // point driver with random idle bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            point_valid <= 1'b0;
        else if (!point_valid || point_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                point_valid <= 1'b0;
            end
            else if (feed_q.size() != 0 && idle_on && $urandom_range(0, 4) == 0)
            begin
                send_gap <= $urandom_range(0, 9);
                point_valid <= 1'b0;
            end
            else if (feed_q.size() != 0)
            begin
                point <= feed_q.pop_front();
                point_valid <= 1'b1;
            end
            else
                point_valid <= 1'b0;
        end
    end

    // result back-pressure in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 9);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // monitor: check results, predict from accepted points
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            point_taken <= point_valid && !point_stall;
            if (result_valid && !result_stall)
                check_result(result);
            if (point_valid && !point_stall)
                absorb_point(point);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        sgfm_cfg_reg_t which;
        for (int d = 0; d < LANES; d++)
        begin
            lower_b[d] = LOWER_RESET;
            upper_b[d] = UPPER_RESET;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset bounds: level 0 means, deepest level, level above the maximum,
        // mean clipping and surplus extremes
        feed_q.push_back(uniform_point(5'd0, 16'd0, 32'sd65536, 1'b0));
        feed_q.push_back(uniform_point(5'd0, 16'd1, -32'sd65536, 1'b0));
        feed_q.push_back(uniform_point(LEVEL_W'(MAX_LEVEL), 16'hFFFF, S32_MAX, 1'b0));
        feed_q.push_back(uniform_point(5'd31, 16'hFFFF, S32_MIN, 1'b0));
        feed_q.push_back(uniform_point(5'd1, 16'd4, 32'sd1, 1'b0));
        feed_q.push_back(uniform_point(5'd1, 16'd1, 32'sd65536, 1'b1));
        feed_q.push_back(uniform_point(5'd17, 16'h0003, 32'sd131072, 1'b1));
        feed_q.push_back(uniform_point(5'd0, 16'h8000, S32_MAX, 1'b1));
        drain();

        // widest and reversed bounds, driving the product and the sum into clipping
        program_bound(CFG_LOWER_0, S32_MIN);
        program_bound(CFG_UPPER_0, S32_MAX);
        program_bound(CFG_LOWER_1, S32_MIN);
        program_bound(CFG_UPPER_1, S32_MAX);
        program_bound(CFG_LOWER_2, S32_MAX);
        program_bound(CFG_UPPER_2, S32_MIN);
        program_bound(CFG_LOWER_3, S32_MAX);
        program_bound(CFG_UPPER_3, S32_MIN);
        for (int n = 0; n < 4; n++)
            feed_q.push_back(uniform_point(5'd1, 16'd1, S32_MAX, n == 3));
        for (int n = 0; n < 4; n++)
            feed_q.push_back(uniform_point(5'd1, 16'd1, S32_MIN, n == 3));
        feed_q.push_back(uniform_point(5'd2, 16'd3, 32'sd0, 1'b1));
        drain();

        // random phases, each under fresh bounds and ending on a last point
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            which = which.first();
            do
            begin
                program_bound(which, pick_bound(PHASE_STYLE[phase], which));
                which = which.next();
            end
            while (which != which.first());
            for (int n = 0; n < PHASE_POINTS; n++)
                feed_q.push_back(random_point(n == PHASE_POINTS - 1 ||
                                              $urandom_range(0, 19) == 0));
            drain();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sgfm_pkg.sv
rtl/sgfm_lane.sv
rtl/sgfm_merge.sv
rtl/sparse_grid_first_moment.sv
rtl/sgfm_checker.sv
sim/tb.sv
